FILE: hdl/ppid_pkg.sv
`timescale 1ns / 1ps

package ppid_pkg;

  // fixed-point format of the gains
  localparam int GAIN_FRAC_BITS = 8;

  localparam int GAIN_W   = 16;
  localparam int SMP_W    = 16;
  localparam int ERR_W    = 17;
  localparam int SUM_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_UPPER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOWER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;

  // reset values
  localparam logic [GAIN_W-1:0]       RST_GAIN_PROP      = 16'd13312;
  localparam logic [GAIN_W-1:0]       RST_GAIN_INTEG     = 16'd128;
  localparam logic [GAIN_W-1:0]       RST_GAIN_DERIV     = 16'd64000;
  localparam logic signed [SMP_W-1:0] RST_DRIVE_UPPER    = 16'sd9000;
  localparam logic signed [SMP_W-1:0] RST_DRIVE_LOWER    = -16'sd9000;
  localparam logic signed [SUM_W-1:0] RST_INTEGRAL_LIMIT = 32'sd500;

  typedef struct packed {
    logic [GAIN_W-1:0]       gain_prop;
    logic [GAIN_W-1:0]       gain_integ;
    logic [GAIN_W-1:0]       gain_deriv;
    logic signed [SMP_W-1:0] drive_upper;
    logic signed [SMP_W-1:0] drive_lower;
    logic signed [SUM_W-1:0] integral_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] last_error;
    logic signed [SUM_W-1:0] error_sum;
  } state_t;

endpackage

FILE: hdl/ppid_cfg_regs.sv
`timescale 1ns / 1ps

module ppid_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [ppid_pkg::CFG_DAT_W-1:0]     wr_data,
  output ppid_pkg::cfg_t                     cfg
);

  ppid_pkg::cfg_t cfg_r;
  ppid_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        ppid_pkg::REG_GAIN_PROP:      cfg_nxt.gain_prop      = wr_data[15:0];
        ppid_pkg::REG_GAIN_INTEG:     cfg_nxt.gain_integ     = wr_data[15:0];
        ppid_pkg::REG_GAIN_DERIV:     cfg_nxt.gain_deriv     = wr_data[15:0];
        ppid_pkg::REG_DRIVE_UPPER:    cfg_nxt.drive_upper    = $signed(wr_data[15:0]);
        ppid_pkg::REG_DRIVE_LOWER:    cfg_nxt.drive_lower    = $signed(wr_data[15:0]);
        ppid_pkg::REG_INTEGRAL_LIMIT: cfg_nxt.integral_limit = $signed(wr_data);
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop      <= ppid_pkg::RST_GAIN_PROP;
      cfg_r.gain_integ     <= ppid_pkg::RST_GAIN_INTEG;
      cfg_r.gain_deriv     <= ppid_pkg::RST_GAIN_DERIV;
      cfg_r.drive_upper    <= ppid_pkg::RST_DRIVE_UPPER;
      cfg_r.drive_lower    <= ppid_pkg::RST_DRIVE_LOWER;
      cfg_r.integral_limit <= ppid_pkg::RST_INTEGRAL_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/ppid_datapath.sv
`timescale 1ns / 1ps

module ppid_datapath (
  input  ppid_pkg::cfg_t                          cfg,
  input  ppid_pkg::state_t                        state,
  input  logic signed [ppid_pkg::SMP_W-1:0]       setpoint,
  input  logic signed [ppid_pkg::SMP_W-1:0]       measured,
  output logic signed [ppid_pkg::SMP_W-1:0]       drive,
  output logic                                    clamped,
  output ppid_pkg::state_t                        state_nxt
);

  localparam int ERR_W  = ppid_pkg::ERR_W;
  localparam int SUM_W  = ppid_pkg::SUM_W;
  localparam int DIFF_W = ERR_W + 1;
  localparam int G_W    = ppid_pkg::GAIN_W + 1;
  localparam int PP_W   = G_W + ERR_W;
  localparam int PI_W   = G_W + SUM_W;
  localparam int PD_W   = G_W + DIFF_W;
  localparam int ACC_W  = PI_W + 2;
  localparam int V_W    = ACC_W - ppid_pkg::GAIN_FRAC_BITS;

  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [G_W-1:0]    gp, gi, gd;
  logic signed [PP_W-1:0]   p_prop;
  logic signed [PI_W-1:0]   p_integ;
  logic signed [PD_W-1:0]   p_deriv;
  logic signed [ACC_W-1:0]  acc;
  logic signed [V_W-1:0]    v_raw, v_hi, v_out;
  logic signed [V_W-1:0]    upper_ext, lower_ext;
  logic                     hit_hi, hit_lo;
  logic signed [SUM_W:0]    sum_raw, sum_hi, limit_ext, min_ext;

  always_comb begin
    err  = ERR_W'(setpoint) - ERR_W'(measured);
    diff = DIFF_W'(err) - DIFF_W'(state.last_error);

    // gains are unsigned, widen with a zero sign bit
    gp = $signed({1'b0, cfg.gain_prop});
    gi = $signed({1'b0, cfg.gain_integ});
    gd = $signed({1'b0, cfg.gain_deriv});

    p_prop  = PP_W'(gp) * PP_W'(err);
    p_integ = PI_W'(gi) * PI_W'(state.error_sum);
    p_deriv = PD_W'(gd) * PD_W'(diff);

    acc = ACC_W'(p_prop) + ACC_W'(p_integ) + ACC_W'(p_deriv);

    // arithmetic shift floors toward minus infinity
    v_raw = acc[ACC_W-1:ppid_pkg::GAIN_FRAC_BITS];

    upper_ext = V_W'(cfg.drive_upper);
    lower_ext = V_W'(cfg.drive_lower);

    // upper clamp first, then lower clamp on the result
    hit_hi = v_raw > upper_ext;
    v_hi   = hit_hi ? upper_ext : v_raw;
    hit_lo = v_hi < lower_ext;
    v_out  = hit_lo ? lower_ext : v_hi;

    drive   = v_out[ppid_pkg::SMP_W-1:0];
    clamped = hit_hi | hit_lo;

    // integral update: clamp above at the limit, saturate at the 32-bit floor
    sum_raw   = (SUM_W+1)'(state.error_sum) + (SUM_W+1)'(err);
    limit_ext = (SUM_W+1)'(cfg.integral_limit);
    min_ext   = $signed({1'b1, {SUM_W{1'b0}}}) >>> 1;
    sum_hi    = (sum_raw > limit_ext) ? limit_ext : sum_raw;
    if (sum_hi < min_ext) begin
      sum_hi = min_ext;
    end

    state_nxt.error_sum  = sum_hi[SUM_W-1:0];
    state_nxt.last_error = err;
  end

endmodule

FILE: hdl/positional_pid_controller_core.sv
`timescale 1ns / 1ps
// positional pid controller with output clamp and one-sided integral limit
// an accepted input passes through the input register, then the result register, to out_tvalid
// throughput: one item per cycle while out_tready holds the result stream open, set by the state_r update loop
// reset (rst_n low, synchronous): gains, clamps and integral limit to defaults, integral and
// previous error to zero, both pipeline registers empty

module positional_pid_controller_core (
  input  logic                               clk,
  input  logic                               rst_n,

  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,   // [15:0] setpoint, [31:16] measured

  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // [15:0] drive
  output logic                               out_tuser,  // [0] clamped

  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppid_pkg::CFG_DAT_W-1:0]     cfg_data
);

  ppid_pkg::cfg_t   cfg;
  ppid_pkg::state_t state_r, state_nxt;

  // input register
  logic                               in_vld_r;
  logic signed [ppid_pkg::SMP_W-1:0]  setpoint_r;
  logic signed [ppid_pkg::SMP_W-1:0]  measured_r;

  // result register
  logic                               out_vld_r;
  logic [15:0]                        drive_r;
  logic                               clamped_r;

  logic signed [ppid_pkg::SMP_W-1:0]  drive_c;
  logic                               clamped_c;
  logic                               advance;

  // registers are always writable; writes must happen only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  ppid_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ppid_datapath u_dp (
    .cfg       (cfg),
    .state     (state_r),
    .setpoint  (setpoint_r),
    .measured  (measured_r),
    .drive     (drive_c),
    .clamped   (clamped_c),
    .state_nxt (state_nxt)
  );

  // item moves from input register to result register when the latter is empty or being read out
  assign advance   = in_vld_r & (~out_vld_r | out_tready);
  // input register refills as soon as it empties or moves on this cycle
  assign in_tready = ~in_vld_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      state_r    <= '0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;   // controller state advances once per item
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid & in_tready) begin
      setpoint_r <= $signed(in_tdata[15:0]);
      measured_r <= $signed(in_tdata[31:16]);
    end
    if (advance) begin
      drive_r   <= drive_c;
      clamped_r <= clamped_c;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = drive_r;
  assign out_tuser  = clamped_r;

endmodule
